// File: rtl/sat_pkg.sv
// Shared types and constants for the section address translator.
// No dependencies; used by sat_cell and section_address_translator_top.
package sat_pkg;

  localparam int unsigned MaxSections = 16;
  localparam int unsigned IdxW        = $clog2(MaxSections);
  localparam int unsigned CntW        = 5;
  localparam int unsigned AddrW       = 32;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_I2F   = 2'd1,
    REQ_F2I   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HDR    = 2'd1,
    ST_BEYOND = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  typedef enum logic {
    CFG_COUNT = 1'b0,
    CFG_ALIGN = 1'b1
  } cfg_e;

  // Transaction travelling down the cell chain, with its result so far.
  typedef struct packed {
    logic [1:0]       req_type;
    logic [IdxW-1:0]  entry_index;
    logic [AddrW-1:0] virt_start;
    logic [AddrW-1:0] virt_size;
    logic [AddrW-1:0] raw_offset;
    logic [AddrW-1:0] raw_size;
    logic [AddrW-1:0] lookup_addr;
    logic             done;
    logic [AddrW-1:0] out_addr;
    logic [1:0]       status;
    logic [IdxW-1:0]  hit_index;
    logic             hit_section;
  } tok_t;

  // Settings shared by every cell.
  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [AddrW-1:0] align_mask;
  } cfg_t;

endpackage

// File: rtl/sat_cell.sv
// One cell of the translator chain: holds one section entry and registers
// the passing transaction. Depends on sat_pkg.
module sat_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [sat_pkg::IdxW-1:0]      cell_idx_i,
  input  sat_pkg::cfg_t                 cfg_i,
  input  logic                          valid_i,
  input  sat_pkg::tok_t                 tok_i,
  output logic                          valid_o,
  output sat_pkg::tok_t                 tok_o
);

  logic [sat_pkg::AddrW-1:0] vstart_q, vsize_q, roff_q, rsize_q, rend_q;
  logic                      valid_q;
  sat_pkg::tok_t             tok_q, tok_d;
  logic                      active, is_first, wr_hit;
  logic [sat_pkg::AddrW-1:0] vend, vdiff;

  assign active   = cfg_i.count > sat_pkg::CntW'(cell_idx_i);
  assign is_first = (cell_idx_i == '0);
  assign wr_hit   = valid_i && (tok_i.req_type == sat_pkg::REQ_WRITE) &&
                    (tok_i.entry_index == cell_idx_i);
  assign vend     = vstart_q + ((vsize_q + cfg_i.align_mask) & ~cfg_i.align_mask);
  assign vdiff    = tok_i.lookup_addr - vstart_q;

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.done && active) begin
      case (tok_i.req_type)
        sat_pkg::REQ_I2F: begin
          if (is_first && tok_i.lookup_addr < vstart_q) begin
            tok_d.done = 1'b1;
            if (tok_i.lookup_addr < roff_q) begin
              tok_d.out_addr = tok_i.lookup_addr;
              tok_d.status   = sat_pkg::ST_OK;
            end else begin
              tok_d.status   = sat_pkg::ST_HDR;
            end
          end else if (tok_i.lookup_addr < vend) begin
            tok_d.done        = 1'b1;
            tok_d.hit_index   = cell_idx_i;
            tok_d.hit_section = 1'b1;
            if (vdiff < rsize_q) begin
              tok_d.out_addr = vdiff + roff_q;
              tok_d.status   = sat_pkg::ST_OK;
            end else begin
              tok_d.status   = sat_pkg::ST_BEYOND;
            end
          end
        end
        sat_pkg::REQ_F2I: begin
          if (is_first && tok_i.lookup_addr < roff_q) begin
            tok_d.done     = 1'b1;
            tok_d.out_addr = tok_i.lookup_addr;
            tok_d.status   = sat_pkg::ST_OK;
          end else if (tok_i.lookup_addr < rend_q) begin
            tok_d.done        = 1'b1;
            tok_d.out_addr    = tok_i.lookup_addr - roff_q + vstart_q;
            tok_d.status      = sat_pkg::ST_OK;
            tok_d.hit_index   = cell_idx_i;
            tok_d.hit_section = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      if (wr_hit) begin
        vstart_q <= tok_i.virt_start;
        vsize_q  <= tok_i.virt_size;
        roff_q   <= tok_i.raw_offset;
        rsize_q  <= tok_i.raw_size;
        rend_q   <= tok_i.raw_offset + tok_i.raw_size;
      end
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

// File: rtl/section_address_translator_top.sv
// Top level of the section address translator: config registers and a
// chain of sat_cell instances. Depends on sat_pkg and sat_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per
//   transaction: write a section entry, translate image address to file
//   offset, or translate file offset to image address.
//   Output channel (out_valid_o / out_stall_i) returns one result per
//   request, in request order.
//   Requests walk a chain of one cell per table entry, one cell a cycle
//   while the chain is not stalled; a new request enters every cycle
//   unless stalled, and a write is seen by every lookup behind it.
//   The config port (cfg_we_i, cfg_index_i, cfg_data_i) sets the section
//   count and the alignment log2; write it only while the chain is empty.
//   Reset clears the chain and sets count 0, alignment log2 12; table
//   contents are undefined until written.
//   While the output is valid and stalled, the whole chain holds and
//   in_stall_o is high.
module section_address_translator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [sat_pkg::CntW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [sat_pkg::IdxW-1:0]     entry_index_i,
  input  logic [sat_pkg::AddrW-1:0]    entry_virt_start_i,
  input  logic [sat_pkg::AddrW-1:0]    entry_virt_size_i,
  input  logic [sat_pkg::AddrW-1:0]    entry_raw_offset_i,
  input  logic [sat_pkg::AddrW-1:0]    entry_raw_size_i,
  input  logic [sat_pkg::AddrW-1:0]    lookup_addr_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sat_pkg::AddrW-1:0]    out_addr_o,
  output logic [1:0]                   status_o,
  output logic [sat_pkg::IdxW-1:0]     hit_index_o,
  output logic                         hit_section_o
);

  logic [sat_pkg::CntW-1:0] count_q;
  logic [4:0]               align_q;
  sat_pkg::cfg_t            cfg;
  logic                     adv;
  sat_pkg::tok_t            tok   [sat_pkg::MaxSections+1];
  logic                     valid [sat_pkg::MaxSections+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      align_q <= 5'd12;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sat_pkg::CFG_COUNT: count_q <= cfg_data_i;
        sat_pkg::CFG_ALIGN: align_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.count      = count_q;
  assign cfg.align_mask = (sat_pkg::AddrW'(1) << align_q) - sat_pkg::AddrW'(1);

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Requests enter with their default result filled in.
  always_comb begin
    tok[0].req_type    = req_type_i;
    tok[0].entry_index = entry_index_i;
    tok[0].virt_start  = entry_virt_start_i;
    tok[0].virt_size   = entry_virt_size_i;
    tok[0].raw_offset  = entry_raw_offset_i;
    tok[0].raw_size    = entry_raw_size_i;
    tok[0].lookup_addr = lookup_addr_i;
    tok[0].out_addr    = '0;
    tok[0].hit_index   = '0;
    tok[0].hit_section = 1'b0;
    case (req_type_i)
      sat_pkg::REQ_WRITE: begin
        tok[0].done   = 1'b1;
        tok[0].status = sat_pkg::ST_OK;
      end
      sat_pkg::REQ_I2F, sat_pkg::REQ_F2I: begin
        tok[0].done   = 1'b0;
        tok[0].status = sat_pkg::ST_NONE;
      end
      default: begin
        tok[0].done   = 1'b1;
        tok[0].status = sat_pkg::ST_NONE;
      end
    endcase
  end
  assign valid[0] = in_valid_i;

  for (genvar g = 0; g < sat_pkg::MaxSections; g++) begin : g_cell
    sat_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (sat_pkg::IdxW'(g)),
      .cfg_i      (cfg),
      .valid_i    (valid[g]),
      .tok_i      (tok[g]),
      .valid_o    (valid[g+1]),
      .tok_o      (tok[g+1])
    );
  end

  assign out_valid_o   = valid[sat_pkg::MaxSections];
  assign out_addr_o    = tok[sat_pkg::MaxSections].out_addr;
  assign status_o      = tok[sat_pkg::MaxSections].status;
  assign hit_index_o   = tok[sat_pkg::MaxSections].hit_index;
  assign hit_section_o = tok[sat_pkg::MaxSections].hit_section;

endmodule

// File: dv/tb_section_address_translator_top.sv
// Testbench for section_address_translator_top: directed and random traffic checked
// in order against an in-bench section table predictor.
// Depends on sat_pkg and the RTL under rtl/.
module tb_section_address_translator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sat_pkg::*;

  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    status_e          status;
    logic [IdxW-1:0]  idx;
    logic             hit;
  } xlat_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_index_i;
  logic [CntW-1:0]  cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       req_type_i;
  logic [IdxW-1:0]  entry_index_i;
  logic [AddrW-1:0] entry_virt_start_i;
  logic [AddrW-1:0] entry_virt_size_i;
  logic [AddrW-1:0] entry_raw_offset_i;
  logic [AddrW-1:0] entry_raw_size_i;
  logic [AddrW-1:0] lookup_addr_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [AddrW-1:0] out_addr_o;
  logic [1:0]       status_o;
  logic [IdxW-1:0]  hit_index_o;
  logic             hit_section_o;

  // Predictor state: section table and register copies
  logic [AddrW-1:0] tbl_virt_base [MaxSections];
  logic [AddrW-1:0] tbl_virt_len  [MaxSections];
  logic [AddrW-1:0] tbl_file_base [MaxSections];
  logic [AddrW-1:0] tbl_file_len  [MaxSections];
  logic [CntW-1:0]  active_count = 5'd0;
  logic [4:0]       align_shift  = 5'd12;

  xlat_result_t pending_translations [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit           gaps_on        = 1'b1;
  bit           stalls_on      = 1'b1;

  section_address_translator_top u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .entry_index_i      (entry_index_i),
    .entry_virt_start_i (entry_virt_start_i),
    .entry_virt_size_i  (entry_virt_size_i),
    .entry_raw_offset_i (entry_raw_offset_i),
    .entry_raw_size_i   (entry_raw_size_i),
    .lookup_addr_i      (lookup_addr_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_addr_o         (out_addr_o),
    .status_o           (status_o),
    .hit_index_o        (hit_index_o),
    .hit_section_o      (hit_section_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // power-of-two round up, wraps at 32 bits
  function automatic logic [AddrW-1:0] align_up(input logic [AddrW-1:0] v);
    logic [AddrW-1:0] m;
    m = (32'd1 << align_shift) - 32'd1;
    return (v + m) & ~m;
  endfunction

  function automatic xlat_result_t translate_request(input logic [1:0] kind,
      input logic [IdxW-1:0] idx, input logic [AddrW-1:0] vs, vsz, ro, rs, addr);
    xlat_result_t     r;
    int unsigned      n;
    logic [AddrW-1:0] lim;
    logic [AddrW-1:0] d;
    bit               found;
    r = '0;
    r.status = ST_NONE;
    n = (active_count > MaxSections) ? MaxSections : active_count;
    found = 1'b0;
    if (kind == REQ_WRITE) begin
      tbl_virt_base[idx] = vs;
      tbl_virt_len[idx]  = vsz;
      tbl_file_base[idx] = ro;
      tbl_file_len[idx]  = rs;
      r.status = ST_OK;
    end else if (kind == REQ_I2F && n > 0) begin
      if (addr < tbl_virt_base[0]) begin
        if (addr < tbl_file_base[0]) begin
          r.addr = addr;
          r.status = ST_OK;
        end else begin
          r.status = ST_HDR;
        end
      end else begin
        for (int i = 0; i < n && !found; i++) begin
          lim = tbl_virt_base[i] + align_up(tbl_virt_len[i]);
          if (addr < lim) begin
            found = 1'b1;
            d = addr - tbl_virt_base[i];
            r.idx = IdxW'(i);
            r.hit = 1'b1;
            if (d < tbl_file_len[i]) begin
              r.addr = d + tbl_file_base[i];
              r.status = ST_OK;
            end else begin
              r.status = ST_BEYOND;
            end
          end
        end
      end
    end else if (kind == REQ_F2I && n > 0) begin
      if (addr < tbl_file_base[0]) begin
        r.addr = addr;
        r.status = ST_OK;
      end else begin
        for (int i = 0; i < n && !found; i++) begin
          lim = tbl_file_base[i] + tbl_file_len[i];
          if (addr < lim) begin
            found = 1'b1;
            r.addr = addr - tbl_file_base[i] + tbl_virt_base[i];
            r.status = ST_OK;
            r.idx = IdxW'(i);
            r.hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // Addresses near section edges, the header region and the ends of the range, plus random ones
  function automatic logic [AddrW-1:0] pick_lookup_addr(input logic [1:0] kind);
    int unsigned      i;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] span;
    i = $urandom_range(0, MaxSections - 1);
    if (kind == REQ_I2F) begin
      base = tbl_virt_base[i];
      span = align_up(tbl_virt_len[i]);
    end else begin
      base = tbl_file_base[i];
      span = tbl_file_len[i];
    end
    case ($urandom_range(0, 9))
      0: return base;
      1: return base - 32'd1;
      2: return base + span - 32'd1;
      3: return base + span;
      4: return base + tbl_file_len[i];
      5: return base + ($urandom & 32'h0000_3fff);
      6: return tbl_file_base[0] - 32'($urandom_range(1, 4));
      7: return 32'd0;
      8: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Called and returns at a falling edge; leaves valid high after the transaction.
  task automatic send_request(input logic [1:0] kind, input logic [IdxW-1:0] idx,
      input logic [AddrW-1:0] vs, vsz, ro, rs, addr);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    req_type_i         <= kind;
    entry_index_i      <= idx;
    entry_virt_start_i <= vs;
    entry_virt_size_i  <= vsz;
    entry_raw_offset_i <= ro;
    entry_raw_size_i   <= rs;
    lookup_addr_i      <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_translations.push_back(translate_request(kind, idx, vs, vsz, ro, rs, addr));
    @(negedge clk_i);
  endtask

  task automatic send_write(input logic [IdxW-1:0] idx,
      input logic [AddrW-1:0] vs, vsz, ro, rs);
    send_request(REQ_WRITE, idx, vs, vsz, ro, rs, $urandom);
  endtask

  task automatic send_lookup(input logic [1:0] kind, input logic [AddrW-1:0] addr);
    send_request(kind, IdxW'($urandom), $urandom, $urandom, $urandom, $urandom, addr);
  endtask

  // Register writes only with the pipeline drained
  task automatic write_register(input cfg_e sel, input logic [CntW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_COUNT) active_count = value;
    else align_shift = value;
  endtask

  // Fills all slots. Mostly a contiguous image layout; some near the top of
  // the address space so ends wrap, some pure noise.
  task automatic load_section_layout();
    int unsigned      style;
    logic [AddrW-1:0] vcur;
    logic [AddrW-1:0] rcur;
    logic [AddrW-1:0] vsz;
    logic [AddrW-1:0] rs;
    style = $urandom_range(0, 9);
    vcur = (style == 7) ? 32'hffff_8000 : {16'h0, 4'($urandom_range(1, 4)), 12'h0};
    rcur = (style == 7) ? 32'hffff_f000 : 32'($urandom_range(32'h200, 32'h1000));
    for (int i = 0; i < MaxSections; i++) begin
      if (style > 7) begin
        send_write(IdxW'(i), $urandom, $urandom, $urandom, $urandom);
      end else begin
        vsz = $urandom_range(0, 32'h2800);
        rs  = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(0, 32'h3000));
        send_write(IdxW'(i), vcur, vsz, rcur, rs);
        vcur = vcur + align_up(vsz) + ($urandom_range(0, 1) ? 32'h1000 : 32'h0);
        rcur = rcur + rs;
      end
    end
  endtask

  task automatic test_reset_defaults();
    // zero section count: every lookup misses
    send_lookup(REQ_I2F, 32'h0000_1000);
    send_lookup(REQ_F2I, 32'h0000_0100);
    send_request(REQ_UNUSED, IdxW'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom);
  endtask

  task automatic test_directed_layout();
    send_write(4'd0, 32'h0000_1000, 32'h0000_1234, 32'h0000_0400, 32'h0000_1400);
    send_write(4'd1, 32'h0000_3000, 32'h0000_0800, 32'h0000_1800, 32'h0000_0200);
    send_write(4'd2, 32'h0000_4000, 32'h0000_0000, 32'h0000_1a00, 32'h0000_0000);
    // virtual size rounds up past 2^32 to zero
    send_write(4'd3, 32'hffff_f000, 32'hffff_ffff, 32'hffff_ff00, 32'h0000_0200);
    send_write(4'd15, '1, '1, '1, '1);
    write_register(CFG_COUNT, 5'd4);
    // alignment still at its reset value here
    send_lookup(REQ_I2F, 32'h0000_0000);
    send_lookup(REQ_I2F, 32'h0000_0800);
    send_lookup(REQ_I2F, 32'h0000_1000);
    send_lookup(REQ_I2F, 32'h0000_2500);
    send_lookup(REQ_I2F, 32'h0000_3100);
    send_lookup(REQ_I2F, 32'h0000_3f00);
    send_lookup(REQ_I2F, 32'hffff_ffff);
    send_lookup(REQ_F2I, 32'h0000_03ff);
    send_lookup(REQ_F2I, 32'h0000_0400);
    send_lookup(REQ_F2I, 32'h0000_1900);
    send_lookup(REQ_F2I, 32'hffff_ffff);
    send_lookup(REQ_F2I, 32'h0000_0050);
    send_request(REQ_UNUSED, 4'd3, '1, '1, '1, '1, '1);
  endtask

  task automatic test_random_traffic();
    int unsigned     sel;
    logic [IdxW-1:0] idx;
    logic [1:0]      kind;
    logic [CntW-1:0] cnt;
    logic [4:0]      shift;
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: begin cnt = 5'd1;  shift = 5'd0;  end
        1: begin cnt = 5'd16; shift = 5'd31; end
        2: begin cnt = 5'd31; shift = 5'd12; end
        3: begin cnt = 5'd17; shift = 5'd1;  end
        4: begin cnt = 5'd0;  shift = 5'd20; end
        5: begin cnt = 5'd9;  shift = 5'd12; end
        6: begin cnt = 5'd16; shift = 5'd5;  end
        default: begin
          cnt   = 5'($urandom_range(0, 31));
          shift = 5'($urandom_range(0, 31));
        end
      endcase
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      write_register(CFG_COUNT, cnt);
      write_register(CFG_ALIGN, shift);
      load_section_layout();
      repeat (85) begin
        sel = $urandom_range(0, 19);
        idx = IdxW'($urandom_range(0, MaxSections - 1));
        if (sel < 2) begin
          // resize an entry in place, or scribble over it
          if ($urandom_range(0, 1))
            send_write(idx, tbl_virt_base[idx], $urandom_range(0, 32'h2800),
                       tbl_file_base[idx], $urandom_range(0, 32'h3000));
          else
            send_write(idx, $urandom, $urandom, $urandom, $urandom);
        end else if (sel == 2) begin
          send_request(REQ_UNUSED, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
          kind = sel[0] ? REQ_I2F : REQ_F2I;
          send_lookup(kind, pick_lookup_addr(kind));
        end
      end
    end
  endtask

  task automatic test_streaming_tail();
    logic [1:0] kind;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_register(CFG_COUNT, 5'd16);
    write_register(CFG_ALIGN, 5'($urandom_range(0, 31)));
    load_section_layout();
    repeat (40) begin
      kind = $urandom_range(0, 1) ? REQ_I2F : REQ_F2I;
      send_lookup(kind, pick_lookup_addr(kind));
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    xlat_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_translations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: addr %h status %0d idx %0d hit %0b",
                   out_addr_o, status_o, hit_index_o, hit_section_o);
      end else begin
        exp_res = pending_translations.pop_front();
        if (out_addr_o !== exp_res.addr || status_o !== exp_res.status ||
            hit_index_o !== exp_res.idx || hit_section_o !== exp_res.hit) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp %h st %0d idx %0d hit %0b, got %h st %0d idx %0d hit %0b",
                     exp_res.addr, exp_res.status, exp_res.idx, exp_res.hit,
                     out_addr_o, status_o, hit_index_o, hit_section_o);
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = CFG_COUNT;
    cfg_data_i         = '0;
    in_valid_i         = 1'b0;
    req_type_i         = REQ_WRITE;
    entry_index_i      = '0;
    entry_virt_start_i = '0;
    entry_virt_size_i  = '0;
    entry_raw_offset_i = '0;
    entry_raw_size_i   = '0;
    lookup_addr_i      = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_directed_layout();
    test_random_traffic();
    test_streaming_tail();

    in_valid_i <= 1'b0;
    while (pending_translations.size() != 0) @(negedge clk_i);
    // catch any stray transaction still in the chain
    repeat (2 * MaxSections) @(negedge clk_i);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sat_pkg.sv
rtl/sat_cell.sv
rtl/section_address_translator_top.sv
dv/tb_section_address_translator_top.sv
